// File: hw/rtl/dpne_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpne_pkg
// Shared types, register indexes, status codes and helpers of the depth
// pixel normal estimator.
// ----------------------------------------------------------------------------
package dpne_pkg;

   // field widths of the pixel and depth inputs
   localparam int DEPTH_BITS = 16;
   localparam int COORD_BITS = 12;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_INV_FOCAL_X    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INV_FOCAL_Y    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_X       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_Y       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_DEPTH      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIFF_RATIO     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NEIGHBOUR_STEP = 3'd6;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_CENTER    = 2'd1;
   localparam logic [1:0] ST_NEIGHBOUR = 2'd2;
   localparam logic [1:0] ST_DISCONT   = 2'd3;

   // unit length in Q1.14
   localparam logic [14:0] NORM_ONE = 15'd16384;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_col;
      logic [COORD_BITS-1:0] pixel_row;
      logic [DEPTH_BITS-1:0] depth_center;
      logic [DEPTH_BITS-1:0] depth_left;
      logic [DEPTH_BITS-1:0] depth_right;
      logic [DEPTH_BITS-1:0] depth_up;
      logic [DEPTH_BITS-1:0] depth_down;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [23:0] world_x;
      logic signed [23:0] world_y;
      logic [15:0]        world_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic [14:0]        norm_z;
   } rsp_type;

   typedef struct packed {
      logic [23:0] inv_focal_x;
      logic [23:0] inv_focal_y;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] max_depth;
      logic [15:0] diff_ratio;
      logic [6:0]  neighbour_step;
   } cfg_type;

   // per-pixel results that ride along with the normal math
   typedef struct packed {
      logic [1:0]         status;
      logic signed [23:0] world_x;
      logic signed [23:0] world_y;
      logic [15:0]        world_z;
   } side_type;

   // reduced tangent vectors, two's complement
   typedef struct packed {
      side_type         side;
      logic [2:0][30:0] tu;
      logic [2:0][30:0] tv;
      logic [6:0]       e;
   } tan_type;

   // reduced cross product as magnitude and sign
   typedef struct packed {
      side_type         side;
      logic [2:0][29:0] cmag;
      logic [2:0]       neg;
      logic [6:0]       e;
   } norm_type;

   typedef struct packed {
      norm_type    n;
      logic [61:0] radicand;
   } sqin_type;

   typedef struct packed {
      norm_type    n;
      logic [30:0] root;
   } sqout_type;

   // right shift that brings the largest magnitude below 2^30
   function automatic logic [5:0] reduce_shift(input logic [63:0] v);
      logic [6:0] len;
      len = 7'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) len = 7'(i + 1);
      end
      if (len > 7'd30) return 6'(len - 7'd30);
      return 6'd0;
   endfunction

endpackage

// File: hw/rtl/dpne_tangent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpne_tangent
// Validity checks, back-projection of the centre point and the two
// tangent vectors, scaled by the intrinsics and reduced to 30 bits.
// ----------------------------------------------------------------------------
module dpne_tangent (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  dpne_pkg::req_type in_beat,
   input  dpne_pkg::cfg_type cfg,
   output logic              out_valid,
   output dpne_pkg::tan_type out_beat
);
   import dpne_pkg::*;

   // round, sign and saturate the back-projected coordinate
   function automatic logic signed [23:0] bp_sat(input logic [43:0] a,
                                                input logic [44:0] b,
                                                input logic neg);
      logic [44:0] sum;
      logic [28:0] q;
      sum = 45'(a) + (b >> 12);
      q = sum[44:16];
      if (neg) begin
         if (q > 29'd8388608) return 24'h800000;
         return -q[23:0];
      end
      if (q > 29'd8388607) return 24'h7FFFFF;
      return q[23:0];
   endfunction

   logic [5:0] valid_ff;

   // stage 1 registers
   logic [1:0]         s1_status_ff, s1_status_in;
   logic [15:0]        s1_dc_ff, s1_dl_ff, s1_dr_ff, s1_dt_ff, s1_db_ff;
   logic signed [17:0] s1_u0_ff, s1_ul_ff, s1_ur_ff, s1_v0_ff, s1_vt_ff, s1_vb_ff;
   logic signed [17:0] s1_u0_in, s1_ul_in, s1_ur_in, s1_v0_in, s1_vt_in, s1_vb_in;
   logic [31:0]        s1_mx_ff, s1_my_ff, s1_mx_in, s1_my_in;

   // stage 2 registers
   logic [1:0]         s2_status_ff;
   logic [15:0]        s2_dc_ff;
   logic signed [34:0] s2_pr_ff, s2_pl_ff, s2_pb_ff, s2_pt_ff, s2_tu1_ff, s2_tv0_ff;
   logic signed [34:0] s2_pr_in, s2_pl_in, s2_pb_in, s2_pt_in, s2_tu1_in, s2_tv0_in;
   logic signed [16:0] s2_ddx_ff, s2_ddy_ff, s2_ddx_in, s2_ddy_in;
   logic [43:0]        s2_ax_ff, s2_ay_ff, s2_ax_in, s2_ay_in;
   logic [44:0]        s2_bx_ff, s2_by_ff, s2_bx_in, s2_by_in;
   logic               s2_xneg_ff, s2_yneg_ff;

   // stage 3 to 6 registers
   side_type           s3_side_ff, s3_side_in, s4_side_ff, s5_side_ff, s6_side_ff;
   logic signed [36:0] s3_tu_ff [3], s3_tv_ff [3], s3_tu_in [3], s3_tv_in [3];
   logic signed [61:0] s4_tu_ff [3], s4_tv_ff [3], s4_tu_in [3], s4_tv_in [3];
   logic [60:0]        s5_mu_ff [3], s5_mv_ff [3], s5_mu_in [3], s5_mv_in [3];
   logic [2:0]         s5_su_ff, s5_sv_ff;
   logic [5:0]         s5_ku_ff, s5_kv_ff, s5_ku_in, s5_kv_in;
   logic [2:0][30:0]   s6_tu_ff, s6_tv_ff, s6_tu_in, s6_tv_in;
   logic [6:0]         s6_e_ff, s6_e_in;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   // stage 1: checks, pixel coordinates, back-projection magnitudes
   always_comb begin
      logic [15:0]        nb [4];
      logic [15:0]        dif;
      logic [31:0]        thr;
      logic               any_zero, disc;
      logic signed [17:0] col_s, row_s, step_s, cx_s, cy_s;
      logic [17:0]        xm, ym;
      nb[0] = in_beat.depth_left;
      nb[1] = in_beat.depth_right;
      nb[2] = in_beat.depth_up;
      nb[3] = in_beat.depth_down;
      thr = 32'(in_beat.depth_center) * 32'(cfg.diff_ratio);
      any_zero = 1'b0;
      disc = 1'b0;
      for (int i = 0; i < 4; i++) begin
         dif = (nb[i] > in_beat.depth_center) ? nb[i] - in_beat.depth_center
                                              : in_beat.depth_center - nb[i];
         if (nb[i] == 16'd0) any_zero = 1'b1;
         if ({dif, 16'd0} > thr) disc = 1'b1;
      end
      if (in_beat.depth_center == 16'd0 || in_beat.depth_center > cfg.max_depth)
         s1_status_in = ST_CENTER;
      else if (any_zero)
         s1_status_in = ST_NEIGHBOUR;
      else if (disc)
         s1_status_in = ST_DISCONT;
      else
         s1_status_in = ST_OK;

      col_s  = $signed({6'd0, in_beat.pixel_col});
      row_s  = $signed({6'd0, in_beat.pixel_row});
      step_s = $signed({11'd0, cfg.neighbour_step});
      cx_s   = $signed({2'd0, cfg.center_x});
      cy_s   = $signed({2'd0, cfg.center_y});
      s1_u0_in = (col_s <<< 4) - cx_s;
      s1_ul_in = ((col_s - step_s) <<< 4) - cx_s;
      s1_ur_in = ((col_s + step_s) <<< 4) - cx_s;
      s1_v0_in = (row_s <<< 4) - cy_s;
      s1_vt_in = ((row_s - step_s) <<< 4) - cy_s;
      s1_vb_in = ((row_s + step_s) <<< 4) - cy_s;
      xm = s1_u0_in[17] ? -s1_u0_in : s1_u0_in;
      ym = s1_v0_in[17] ? -s1_v0_in : s1_v0_in;
      s1_mx_in = 32'(xm[15:0]) * 32'(in_beat.depth_center);
      s1_my_in = 32'(ym[15:0]) * 32'(in_beat.depth_center);
   end

   // stage 2: tangent partial products and back-projection products
   always_comb begin
      s2_ddx_in = $signed({1'b0, s1_dr_ff}) - $signed({1'b0, s1_dl_ff});
      s2_ddy_in = $signed({1'b0, s1_db_ff}) - $signed({1'b0, s1_dt_ff});
      s2_pr_in  = s1_ur_ff * $signed({1'b0, s1_dr_ff});
      s2_pl_in  = s1_ul_ff * $signed({1'b0, s1_dl_ff});
      s2_pb_in  = s1_vb_ff * $signed({1'b0, s1_db_ff});
      s2_pt_in  = s1_vt_ff * $signed({1'b0, s1_dt_ff});
      s2_tu1_in = s1_v0_ff * s2_ddx_in;
      s2_tv0_in = s1_u0_ff * s2_ddy_in;
      s2_ax_in  = 44'(s1_mx_ff) * 44'(cfg.inv_focal_x[23:12]);
      s2_ay_in  = 44'(s1_my_ff) * 44'(cfg.inv_focal_y[23:12]);
      s2_bx_in  = 45'(s1_mx_ff) * 45'(cfg.inv_focal_x[11:0]) + 45'd134217728;
      s2_by_in  = 45'(s1_my_ff) * 45'(cfg.inv_focal_y[11:0]) + 45'd134217728;
   end

   // stage 3: tangent vectors, world point
   always_comb begin
      s3_tu_in[0] = s2_pr_ff - s2_pl_ff;
      s3_tu_in[1] = s2_tu1_ff;
      s3_tu_in[2] = s2_ddx_ff <<< 4;
      s3_tv_in[0] = s2_tv0_ff;
      s3_tv_in[1] = s2_pb_ff - s2_pt_ff;
      s3_tv_in[2] = s2_ddy_ff <<< 4;
      s3_side_in.status  = s2_status_ff;
      s3_side_in.world_x = bp_sat(s2_ax_ff, s2_bx_ff, s2_xneg_ff);
      s3_side_in.world_y = bp_sat(s2_ay_ff, s2_by_ff, s2_yneg_ff);
      s3_side_in.world_z = s2_dc_ff;
   end

   // stage 4: scale by the intrinsics
   always_comb begin
      s4_tu_in[0] = s3_tu_ff[0] * $signed({1'b0, cfg.inv_focal_x});
      s4_tu_in[1] = s3_tu_ff[1] * $signed({1'b0, cfg.inv_focal_y});
      s4_tu_in[2] = s3_tu_ff[2] <<< 24;
      s4_tv_in[0] = s3_tv_ff[0] * $signed({1'b0, cfg.inv_focal_x});
      s4_tv_in[1] = s3_tv_ff[1] * $signed({1'b0, cfg.inv_focal_y});
      s4_tv_in[2] = s3_tv_ff[2] <<< 24;
   end

   // stage 5: magnitudes and shift counts
   always_comb begin
      logic [61:0] mu, mv;
      logic [60:0] ou, ov;
      ou = '0;
      ov = '0;
      for (int i = 0; i < 3; i++) begin
         mu = s4_tu_ff[i][61] ? -s4_tu_ff[i] : s4_tu_ff[i];
         mv = s4_tv_ff[i][61] ? -s4_tv_ff[i] : s4_tv_ff[i];
         s5_mu_in[i] = mu[60:0];
         s5_mv_in[i] = mv[60:0];
         ou = ou | mu[60:0];
         ov = ov | mv[60:0];
      end
      s5_ku_in = reduce_shift({3'd0, ou});
      s5_kv_in = reduce_shift({3'd0, ov});
   end

   // stage 6: shift toward zero and restore the signs
   always_comb begin
      logic [60:0] su, sv;
      for (int i = 0; i < 3; i++) begin
         su = s5_mu_ff[i] >> s5_ku_ff;
         sv = s5_mv_ff[i] >> s5_kv_ff;
         s6_tu_in[i] = s5_su_ff[i] ? -{1'b0, su[29:0]} : {1'b0, su[29:0]};
         s6_tv_in[i] = s5_sv_ff[i] ? -{1'b0, sv[29:0]} : {1'b0, sv[29:0]};
      end
      s6_e_in = 7'(s5_ku_ff) + 7'(s5_kv_ff);
   end

   // pipeline data
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_status_ff <= s1_status_in;
         s1_dc_ff     <= in_beat.depth_center;
         s1_dl_ff     <= in_beat.depth_left;
         s1_dr_ff     <= in_beat.depth_right;
         s1_dt_ff     <= in_beat.depth_up;
         s1_db_ff     <= in_beat.depth_down;
         s1_u0_ff     <= s1_u0_in;
         s1_ul_ff     <= s1_ul_in;
         s1_ur_ff     <= s1_ur_in;
         s1_v0_ff     <= s1_v0_in;
         s1_vt_ff     <= s1_vt_in;
         s1_vb_ff     <= s1_vb_in;
         s1_mx_ff     <= s1_mx_in;
         s1_my_ff     <= s1_my_in;

         s2_status_ff <= s1_status_ff;
         s2_dc_ff     <= s1_dc_ff;
         s2_pr_ff     <= s2_pr_in;
         s2_pl_ff     <= s2_pl_in;
         s2_pb_ff     <= s2_pb_in;
         s2_pt_ff     <= s2_pt_in;
         s2_tu1_ff    <= s2_tu1_in;
         s2_tv0_ff    <= s2_tv0_in;
         s2_ddx_ff    <= s2_ddx_in;
         s2_ddy_ff    <= s2_ddy_in;
         s2_ax_ff     <= s2_ax_in;
         s2_ay_ff     <= s2_ay_in;
         s2_bx_ff     <= s2_bx_in;
         s2_by_ff     <= s2_by_in;
         s2_xneg_ff   <= s1_u0_ff[17];
         s2_yneg_ff   <= s1_v0_ff[17];

         s3_side_ff   <= s3_side_in;
         s4_side_ff   <= s3_side_ff;
         s5_side_ff   <= s4_side_ff;
         s6_side_ff   <= s5_side_ff;
         for (int i = 0; i < 3; i++) begin
            s3_tu_ff[i] <= s3_tu_in[i];
            s3_tv_ff[i] <= s3_tv_in[i];
            s4_tu_ff[i] <= s4_tu_in[i];
            s4_tv_ff[i] <= s4_tv_in[i];
            s5_mu_ff[i] <= s5_mu_in[i];
            s5_mv_ff[i] <= s5_mv_in[i];
            s5_su_ff[i] <= s4_tu_ff[i][61];
            s5_sv_ff[i] <= s4_tv_ff[i][61];
         end
         s5_ku_ff <= s5_ku_in;
         s5_kv_ff <= s5_kv_in;
         s6_tu_ff <= s6_tu_in;
         s6_tv_ff <= s6_tv_in;
         s6_e_ff  <= s6_e_in;
      end
   end

   assign out_valid     = valid_ff[5];
   assign out_beat.side = s6_side_ff;
   assign out_beat.tu   = s6_tu_ff;
   assign out_beat.tv   = s6_tv_ff;
   assign out_beat.e    = s6_e_ff;

endmodule

// File: hw/rtl/dpne_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpne_cross
// Cross product of the tangents, reduction to 30 bits and the sum of
// squares that feeds the square root.
// ----------------------------------------------------------------------------
module dpne_cross (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  dpne_pkg::tan_type  in_beat,
   output logic               out_valid,
   output dpne_pkg::sqin_type out_beat
);
   import dpne_pkg::*;

   logic [5:0] valid_ff;

   side_type           c1_side_ff, c2_side_ff, c3_side_ff;
   logic [6:0]         c1_e_ff, c2_e_ff, c3_e_ff;
   logic signed [61:0] c1_pa_ff [3], c1_pb_ff [3], c1_pa_in [3], c1_pb_in [3];
   logic signed [62:0] c2_c_ff [3], c2_c_in [3];
   logic [61:0]        c3_m_ff [3], c3_m_in [3];
   logic [2:0]         c3_s_ff;
   logic [5:0]         c3_k_ff, c3_k_in;
   norm_type           c4_n_ff, c4_n_in, c5_n_ff, c6_n_ff;
   logic [59:0]        c5_sq_ff [3], c5_sq_in [3];
   logic [61:0]        c6_sum_ff, c6_sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   // partial products of the cross product
   always_comb begin
      logic signed [30:0] u [3];
      logic signed [30:0] v [3];
      for (int i = 0; i < 3; i++) begin
         u[i] = $signed(in_beat.tu[i]);
         v[i] = $signed(in_beat.tv[i]);
      end
      c1_pa_in[0] = u[1] * v[2];
      c1_pb_in[0] = u[2] * v[1];
      c1_pa_in[1] = u[2] * v[0];
      c1_pb_in[1] = u[0] * v[2];
      c1_pa_in[2] = u[0] * v[1];
      c1_pb_in[2] = u[1] * v[0];
   end

   // differences, magnitudes and shift count
   always_comb begin
      logic [62:0] m;
      logic [61:0] o;
      o = '0;
      for (int i = 0; i < 3; i++) begin
         c2_c_in[i] = c1_pa_ff[i] - c1_pb_ff[i];
         m = c2_c_ff[i][62] ? -c2_c_ff[i] : c2_c_ff[i];
         c3_m_in[i] = m[61:0];
         o = o | m[61:0];
      end
      c3_k_in = reduce_shift({2'd0, o});
   end

   // shift toward zero, then squares and their sum
   always_comb begin
      logic [61:0] sm;
      c4_n_in.side = c3_side_ff;
      c4_n_in.e    = c3_e_ff + 7'(c3_k_ff);
      for (int i = 0; i < 3; i++) begin
         sm = c3_m_ff[i] >> c3_k_ff;
         c4_n_in.cmag[i] = sm[29:0];
         c4_n_in.neg[i]  = c3_s_ff[i] & (sm[29:0] != 30'd0);
         c5_sq_in[i] = 60'(c4_n_ff.cmag[i]) * 60'(c4_n_ff.cmag[i]);
      end
      c6_sum_in = 62'(c5_sq_ff[0]) + 62'(c5_sq_ff[1]) + 62'(c5_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_side_ff <= in_beat.side;
         c1_e_ff    <= in_beat.e;
         c2_side_ff <= c1_side_ff;
         c2_e_ff    <= c1_e_ff;
         c3_side_ff <= c2_side_ff;
         c3_e_ff    <= c2_e_ff;
         for (int i = 0; i < 3; i++) begin
            c1_pa_ff[i] <= c1_pa_in[i];
            c1_pb_ff[i] <= c1_pb_in[i];
            c2_c_ff[i]  <= c2_c_in[i];
            c3_m_ff[i]  <= c3_m_in[i];
            c3_s_ff[i]  <= c2_c_ff[i][62];
            c5_sq_ff[i] <= c5_sq_in[i];
         end
         c3_k_ff   <= c3_k_in;
         c4_n_ff   <= c4_n_in;
         c5_n_ff   <= c4_n_ff;
         c6_n_ff   <= c5_n_ff;
         c6_sum_ff <= c6_sum_in;
      end
   end

   assign out_valid         = valid_ff[5];
   assign out_beat.n        = c6_n_ff;
   assign out_beat.radicand = c6_sum_ff;

endmodule

// File: hw/rtl/dpne_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpne_sqrt
// Pipelined floor square root, two result bits per stage, 16 stages.
// ----------------------------------------------------------------------------
module dpne_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  dpne_pkg::sqin_type  in_beat,
   output logic                out_valid,
   output dpne_pkg::sqout_type out_beat
);
   import dpne_pkg::*;

   localparam int ROOT_BITS   = 31;
   localparam int BITS_PER_ST = 2;
   localparam int ROOT_STAGES = (ROOT_BITS + BITS_PER_ST - 1) / BITS_PER_ST;

   logic [ROOT_STAGES-1:0] valid_ff;
   norm_type               n_ff    [ROOT_STAGES];
   logic [61:0]            rem_ff  [ROOT_STAGES];
   logic [61:0]            rem_in  [ROOT_STAGES];
   logic [ROOT_BITS-1:0]   root_ff [ROOT_STAGES];
   logic [ROOT_BITS-1:0]   root_in [ROOT_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[ROOT_STAGES-2:0], in_valid};
      end
   end

   for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
      logic [61:0]          rem_src;
      logic [ROOT_BITS-1:0] root_src;
      norm_type             n_src;

      if (s == 0) begin : g_first
         assign rem_src  = in_beat.radicand;
         assign root_src = '0;
         assign n_src    = in_beat.n;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign n_src    = n_ff[s-1];
      end

      // restoring root digits: try (q + 2^i)^2 - q^2 against the remainder
      always_comb begin
         logic [63:0]          r, t;
         logic [ROOT_BITS-1:0] q;
         int                   i;
         r = {2'd0, rem_src};
         q = root_src;
         for (int j = 0; j < BITS_PER_ST; j++) begin
            i = ROOT_BITS - 1 - BITS_PER_ST * s - j;
            if (i >= 0) begin
               t = (64'(q) << (i + 1)) | (64'd1 << (2 * i));
               if (r >= t) begin
                  r = r - t;
                  q = q | (ROOT_BITS'(1) << i);
               end
            end
         end
         rem_in[s]  = r[61:0];
         root_in[s] = q;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            n_ff[s]    <= n_src;
         end
      end
   end

   assign out_valid     = valid_ff[ROOT_STAGES-1];
   assign out_beat.n    = n_ff[ROOT_STAGES-1];
   assign out_beat.root = root_ff[ROOT_STAGES-1];

endmodule

// File: hw/rtl/dpne_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpne_div
// Normalization: tiny-normal test, three pipelined restoring dividers
// (two quotient bits per stage) and the output register.
// ----------------------------------------------------------------------------
module dpne_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  dpne_pkg::sqout_type in_beat,
   output logic                out_valid,
   output dpne_pkg::rsp_type   out_beat
);
   import dpne_pkg::*;

   localparam int Q_BITS      = 15;
   localparam int BITS_PER_ST = 2;
   localparam int DIV_STAGES  = (Q_BITS + BITS_PER_ST - 1) / BITS_PER_ST;
   localparam int ST          = DIV_STAGES + 1;

   // stage 0 is the setup, stages 1..DIV_STAGES divide, then the output
   logic [ST:0]              valid_ff;
   norm_type                 n_ff   [ST];
   logic                     big_ff [ST];
   logic [31:0]              den_ff [ST];
   logic [2:0][45:0]         rem_ff [ST];
   logic [2:0][45:0]         rem_in [ST];
   logic [2:0][Q_BITS-1:0]   quo_ff [ST];
   logic [2:0][Q_BITS-1:0]   quo_in [ST];
   logic                     big_in;
   rsp_type                  rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[ST-1:0], in_valid};
      end
   end

   // setup: tiny test and numerators |c|*32768 + L over 2L
   always_comb begin
      logic [6:0] sh;
      sh = 7'd56 - in_beat.n.e;
      if (in_beat.n.e > 7'd56)
         big_in = in_beat.root != 31'd0;
      else if (sh >= 7'd31)
         big_in = 1'b0;
      else
         big_in = in_beat.root > (31'd1 << sh);
      for (int i = 0; i < 3; i++) begin
         rem_in[0][i] = {1'b0, in_beat.n.cmag[i], 15'd0} + 46'(in_beat.root);
         quo_in[0][i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff[0]   <= in_beat.n;
         big_ff[0] <= big_in;
         den_ff[0] <= {in_beat.root, 1'b0};
         rem_ff[0] <= rem_in[0];
         quo_ff[0] <= quo_in[0];
      end
   end

   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
      // two quotient bits against the shifted divisor
      always_comb begin
         logic [46:0]       r, t;
         logic [Q_BITS-1:0] q;
         int                i;
         for (int k = 0; k < 3; k++) begin
            r = {1'b0, rem_ff[s-1][k]};
            q = quo_ff[s-1][k];
            for (int j = 0; j < BITS_PER_ST; j++) begin
               i = Q_BITS - 1 - BITS_PER_ST * (s - 1) - j;
               if (i >= 0) begin
                  t = 47'(den_ff[s-1]) << i;
                  if (r >= t) begin
                     r = r - t;
                     q = q | (Q_BITS'(1) << i);
                  end
               end
            end
            rem_in[s][k] = r[45:0];
            quo_in[s][k] = q;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff[s]   <= n_ff[s-1];
            big_ff[s] <= big_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   // output beat: clamp, orient toward the camera, unit z for tiny normals, zero rejected pixels
   always_comb begin
      logic [Q_BITS-1:0] q [3];
      norm_type          n;
      n = n_ff[DIV_STAGES];
      for (int k = 0; k < 3; k++) begin
         q[k] = (quo_ff[DIV_STAGES][k] > NORM_ONE) ? NORM_ONE : quo_ff[DIV_STAGES][k];
      end
      rsp_in = '0;
      rsp_in.status = n.side.status;
      if (n.side.status == ST_OK) begin
         rsp_in.world_x = n.side.world_x;
         rsp_in.world_y = n.side.world_y;
         rsp_in.world_z = n.side.world_z;
         if (!big_ff[DIV_STAGES]) begin
            rsp_in.norm_z = NORM_ONE;
         end else begin
            rsp_in.norm_x = (n.neg[0] ^ n.neg[2]) ? -{1'b0, q[0]} : {1'b0, q[0]};
            rsp_in.norm_y = (n.neg[1] ^ n.neg[2]) ? -{1'b0, q[1]} : {1'b0, q[1]};
            rsp_in.norm_z = q[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff[ST];
   assign out_beat  = rsp_ff;

endmodule

// File: hw/rtl/depth_pixel_normal_estimate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_normal_estimate
// Throughput: one pixel per cycle; the 16-stage square root and the
// 8-stage dividers are fully pipelined and set the latency.
// A stalled rsp beat holds the whole pipeline in place.
// Reset (synchronous): clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module depth_pixel_normal_estimate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dpne_pkg::req_type                   req_beat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dpne_pkg::rsp_type                   rsp_beat,
   input  logic                                csr_wr_en,
   input  logic [dpne_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dpne_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import dpne_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      adv;
   logic      tan_valid, crs_valid, sq_valid;
   tan_type   tan_beat;
   sqin_type  crs_beat;
   sqout_type sq_beat;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_INV_FOCAL_X:    cfg_in.inv_focal_x    = csr_data;
            REG_INV_FOCAL_Y:    cfg_in.inv_focal_y    = csr_data;
            REG_CENTER_X:       cfg_in.center_x       = csr_data[15:0];
            REG_CENTER_Y:       cfg_in.center_y       = csr_data[15:0];
            REG_MAX_DEPTH:      cfg_in.max_depth      = csr_data[15:0];
            REG_DIFF_RATIO:     cfg_in.diff_ratio     = csr_data[15:0];
            REG_NEIGHBOUR_STEP: cfg_in.neighbour_step = csr_data[6:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_focal_x    <= 24'd16777;
         cfg_ff.inv_focal_y    <= 24'd16777;
         cfg_ff.center_x       <= 16'd5120;
         cfg_ff.center_y       <= 16'd3840;
         cfg_ff.max_depth      <= 16'd10000;
         cfg_ff.diff_ratio     <= 16'd6554;
         cfg_ff.neighbour_step <= 7'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // the pipeline moves unless the output beat is held
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   dpne_tangent u_tangent (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_beat   (req_beat),
      .cfg       (cfg_ff),
      .out_valid (tan_valid),
      .out_beat  (tan_beat)
   );

   dpne_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (tan_valid),
      .in_beat   (tan_beat),
      .out_valid (crs_valid),
      .out_beat  (crs_beat)
   );

   dpne_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (crs_valid),
      .in_beat   (crs_beat),
      .out_valid (sq_valid),
      .out_beat  (sq_beat)
   );

   dpne_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_beat   (sq_beat),
      .out_valid (rsp_valid),
      .out_beat  (rsp_beat)
   );

endmodule

// File: bench/tb_depth_pixel_normal_estimate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_pixel_normal_estimate
// Drives depth pixels into the normal estimator under random idling on both
// sides, predicts every result in fixed point and compares field by field.
// ----------------------------------------------------------------------------

// expected results of accepted pixels, oldest first
class normal_scoreboard;
   dpne_pkg::cfg_type  cfg;
   dpne_pkg::rsp_type  pending[$];
   int                 errors;

   function new();
      errors = 0;
      cfg.inv_focal_x    = 24'd16777;
      cfg.inv_focal_y    = 24'd16777;
      cfg.center_x       = 16'd5120;
      cfg.center_y       = 16'd3840;
      cfg.max_depth      = 16'd10000;
      cfg.diff_ratio     = 16'd6554;
      cfg.neighbour_step = 7'd2;
   endfunction

   function void set_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
         dpne_pkg::REG_INV_FOCAL_X:    cfg.inv_focal_x = val;
         dpne_pkg::REG_INV_FOCAL_Y:    cfg.inv_focal_y = val;
         dpne_pkg::REG_CENTER_X:       cfg.center_x = val[15:0];
         dpne_pkg::REG_CENTER_Y:       cfg.center_y = val[15:0];
         dpne_pkg::REG_MAX_DEPTH:      cfg.max_depth = val[15:0];
         dpne_pkg::REG_DIFF_RATIO:     cfg.diff_ratio = val[15:0];
         dpne_pkg::REG_NEIGHBOUR_STEP: cfg.neighbour_step = val[6:0];
         default: ;
      endcase
   endfunction

   static function longint unsigned absv(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   static function longint shrz(longint v, int k);
      longint unsigned m;
      m = absv(v) >> k;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   // shift all three toward zero until the largest is below 2^bits
   static function int shrink(ref longint v[3], input int bits);
      longint unsigned mx;
      int k;
      mx = 0;
      k = 0;
      for (int i = 0; i < 3; i++) if (absv(v[i]) > mx) mx = absv(v[i]);
      while ((mx >> k) >= (64'd1 << bits)) k++;
      for (int i = 0; i < 3; i++) v[i] = shrz(v[i], k);
      return k;
   endfunction

   static function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   static function logic [23:0] project(longint u, longint unsigned d,
                                        longint unsigned inv);
      longint unsigned m, a, b, q;
      m = absv(u) * d;
      a = m * (inv >> 12);
      b = m * (inv & 64'hFFF) + (64'd1 << 27);
      q = (a + (b >> 12)) >> 16;
      if (u < 0) return q > 64'd8388608 ? 24'h800000 : 24'(-longint'(q));
      return q > 64'd8388607 ? 24'h7FFFFF : 24'(q);
   endfunction

   function dpne_pkg::rsp_type estimate(dpne_pkg::req_type p);
      dpne_pkg::rsp_type r;
      longint unsigned dc, thr, sq, len, q, diff;
      longint unsigned nb[4];
      longint x, y, s, u0, ul, ur, v0, vt, vb, dl, dr, dt, db;
      longint tu[3], tv[3], c[3], n[3];
      int e;
      bit big;
      r = '0;
      dc = p.depth_center;
      nb[0] = p.depth_left; nb[1] = p.depth_right;
      nb[2] = p.depth_up;   nb[3] = p.depth_down;
      if (dc == 0 || dc > cfg.max_depth) begin
         r.status = dpne_pkg::ST_CENTER;
         return r;
      end
      if (nb[0] == 0 || nb[1] == 0 || nb[2] == 0 || nb[3] == 0) begin
         r.status = dpne_pkg::ST_NEIGHBOUR;
         return r;
      end
      thr = dc * cfg.diff_ratio;
      for (int i = 0; i < 4; i++) begin
         diff = nb[i] > dc ? nb[i] - dc : dc - nb[i];
         if ((diff << 16) > thr) begin
            r.status = dpne_pkg::ST_DISCONT;
            return r;
         end
      end
      x = p.pixel_col; y = p.pixel_row;
      dl = nb[0]; dr = nb[1]; dt = nb[2]; db = nb[3];
      s = cfg.neighbour_step;
      u0 = x * 16 - longint'(cfg.center_x);
      ul = (x - s) * 16 - longint'(cfg.center_x);
      ur = (x + s) * 16 - longint'(cfg.center_x);
      v0 = y * 16 - longint'(cfg.center_y);
      vt = (y - s) * 16 - longint'(cfg.center_y);
      vb = (y + s) * 16 - longint'(cfg.center_y);
      tu[0] = ur * dr - ul * dl;
      tu[1] = v0 * (dr - dl);
      tu[2] = (dr - dl) * 16;
      tv[0] = u0 * (db - dt);
      tv[1] = vb * db - vt * dt;
      tv[2] = (db - dt) * 16;
      e = shrink(tu, 38) + shrink(tv, 38);
      tu[0] *= longint'(cfg.inv_focal_x); tu[1] *= longint'(cfg.inv_focal_y);
      tu[2] *= longint'(1) << 24;
      tv[0] *= longint'(cfg.inv_focal_x); tv[1] *= longint'(cfg.inv_focal_y);
      tv[2] *= longint'(1) << 24;
      e += shrink(tu, 30) + shrink(tv, 30);
      c[0] = tu[1] * tv[2] - tu[2] * tv[1];
      c[1] = tu[2] * tv[0] - tu[0] * tv[2];
      c[2] = tu[0] * tv[1] - tu[1] * tv[0];
      e += shrink(c, 30);
      sq = 0;
      for (int i = 0; i < 3; i++) sq += absv(c[i]) * absv(c[i]);
      len = root_floor(sq);
      if (e > 56) big = len >= 1;
      else big = len > (64'd1 << (56 - e));
      if (!big) begin
         n[0] = 0; n[1] = 0; n[2] = 16384;
      end else begin
         for (int i = 0; i < 3; i++) begin
            q = (absv(c[i]) * 32768 + len) / (2 * len);
            if (q > 16384) q = 16384;
            n[i] = c[i] < 0 ? -longint'(q) : longint'(q);
         end
         if (c[2] < 0) begin
            n[0] = -n[0]; n[1] = -n[1]; n[2] = -n[2];
         end
      end
      r.status  = dpne_pkg::ST_OK;
      r.world_x = project(u0, dc, cfg.inv_focal_x);
      r.world_y = project(v0, dc, cfg.inv_focal_y);
      r.world_z = dc[15:0];
      r.norm_x  = 16'(n[0]);
      r.norm_y  = 16'(n[1]);
      r.norm_z  = 15'(n[2]);
      return r;
   endfunction

   function void note_pixel(dpne_pkg::req_type p);
      pending.insert(pending.size(), estimate(p));
   endfunction

   function void check_result(dpne_pkg::rsp_type a);
      dpne_pkg::rsp_type x;
      if (pending.size() == 0) begin
         $error("unexpected result beat %h", a);
         errors++;
         return;
      end
      x = pending.pop_front();
      if (a.status !== x.status) begin
         $error("status exp %0d got %0d", x.status, a.status); errors++;
      end
      if (a.world_x !== x.world_x) begin
         $error("world_x exp %0d got %0d", x.world_x, a.world_x); errors++;
      end
      if (a.world_y !== x.world_y) begin
         $error("world_y exp %0d got %0d", x.world_y, a.world_y); errors++;
      end
      if (a.world_z !== x.world_z) begin
         $error("world_z exp %0d got %0d", x.world_z, a.world_z); errors++;
      end
      if (a.norm_x !== x.norm_x) begin
         $error("norm_x exp %0d got %0d", x.norm_x, a.norm_x); errors++;
      end
      if (a.norm_y !== x.norm_y) begin
         $error("norm_y exp %0d got %0d", x.norm_y, a.norm_y); errors++;
      end
      if (a.norm_z !== x.norm_z) begin
         $error("norm_z exp %0d got %0d", x.norm_z, a.norm_z); errors++;
      end
   endfunction
endclass

module tb_depth_pixel_normal_estimate;
   import dpne_pkg::*;

   localparam int LATENCY   = 38;
   localparam int MAX_CYCLE = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_beat = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_beat;
   logic    csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   normal_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_rsp = 1'b0;
   int  cycle = 0;

   depth_pixel_normal_estimate uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("depth_pixel_normal_estimate: mismatch");
         $finish;
      end
   end

   // result side: sample at rising edge, pick stall at falling edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_beat);
   end

   always @(negedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
   end

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // offer one pixel and wait for acceptance
   task automatic send_pixel(req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= p;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(p);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   function automatic logic [15:0] near(logic [15:0] d, int spread);
      int v;
      v = int'(d) + $urandom_range(2 * spread) - spread;
      if (v < 1) v = 1;
      if (v > 65535) v = 65535;
      return 16'(v);
   endfunction

   // mostly smooth surfaces, some broken or random pixels
   function automatic req_type rand_pixel();
      req_type p;
      int k;
      p.pixel_col = 12'($urandom);
      p.pixel_row = 12'($urandom);
      k = $urandom_range(99);
      if (k < 10) begin
         p.depth_center = 16'($urandom); p.depth_left = 16'($urandom);
         p.depth_right  = 16'($urandom); p.depth_up   = 16'($urandom);
         p.depth_down   = 16'($urandom);
      end else begin
         p.depth_center = (k < 15) ? 16'($urandom) : 16'($urandom_range(12000, 1));
         p.depth_left  = near(p.depth_center, 1 + p.depth_center / 16);
         p.depth_right = near(p.depth_center, 1 + p.depth_center / 16);
         p.depth_up    = near(p.depth_center, 1 + p.depth_center / 16);
         p.depth_down  = near(p.depth_center, 1 + p.depth_center / 16);
         if (k < 20) p.depth_up = 16'd0;
         else if (k < 24) p.depth_center = 16'd0;
         else if (k < 28) p.depth_right = 16'(p.depth_center * 2 + 1);
         else if (k < 30) p.depth_down = 16'hFFFF;
      end
      return p;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) send_pixel(rand_pixel());
   endtask

   req_type d;
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: flat wall, tilts, each rejection, field extremes
      d = '{12'd320, 12'd240, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000};
      send_pixel(d);
      d = '{12'd0, 12'd0, 16'd1000, 16'd990, 16'd1010, 16'd995, 16'd1005};
      send_pixel(d);
      d = '{12'd4095, 12'd4095, 16'd10000, 16'd9500, 16'd10400, 16'd10100, 16'd9900};
      send_pixel(d);
      d = '{12'd100, 12'd100, 16'd0, 16'd5, 16'd5, 16'd5, 16'd5};
      send_pixel(d);
      d = '{12'd100, 12'd100, 16'd10001, 16'd10001, 16'd10001, 16'd10001, 16'd10001};
      send_pixel(d);
      d = '{12'd5, 12'd9, 16'd500, 16'd0, 16'd500, 16'd500, 16'd500};
      send_pixel(d);
      d = '{12'd5, 12'd9, 16'd500, 16'd500, 16'd500, 16'd500, 16'd0};
      send_pixel(d);
      d = '{12'd5, 12'd9, 16'd500, 16'd500, 16'd600, 16'd500, 16'd500};
      send_pixel(d);
      d = '{12'd5, 12'd9, 16'd500, 16'd500, 16'd500, 16'd400, 16'd500};
      send_pixel(d);
      d = '{12'd2048, 12'd1024, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
      send_pixel(d);
      d = '{12'hAAA, 12'h555, 16'd7000, 16'd7100, 16'd6900, 16'd7050, 16'd6950};
      send_pixel(d);
      drain();

      // extreme registers: wide open thresholds, largest and smallest focal reciprocals
      write_reg(REG_INV_FOCAL_X, 24'hFFFFFF);
      write_reg(REG_INV_FOCAL_Y, 24'd1);
      write_reg(REG_CENTER_X, 16'hFFFF);
      write_reg(REG_CENTER_Y, 16'd0);
      write_reg(REG_MAX_DEPTH, 16'hFFFF);
      write_reg(REG_DIFF_RATIO, 16'hFFFF);
      write_reg(REG_NEIGHBOUR_STEP, 7'd64);
      d = '{12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'h8000, 16'hFFFF};
      send_pixel(d);
      d = '{12'd0, 12'hFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF};
      send_pixel(d);
      drain();
      write_reg(REG_NEIGHBOUR_STEP, 7'd0);
      write_reg(REG_NEIGHBOUR_STEP, 7'd0);
      d = '{12'd10, 12'd20, 16'd3000, 16'd3100, 16'd2900, 16'd3000, 16'd3050};
      send_pixel(d);
      drain();
      write_reg(REG_NEIGHBOUR_STEP, 7'd127);
      write_reg(REG_DIFF_RATIO, 16'd0);
      d = '{12'd10, 12'd20, 16'd3000, 16'd3000, 16'd3000, 16'd3000, 16'd3000};
      send_pixel(d);
      d = '{12'd10, 12'd20, 16'd3000, 16'd3001, 16'd3000, 16'd3000, 16'd3000};
      send_pixel(d);
      drain();
      write_reg(REG_MAX_DEPTH, 16'd0);
      send_pixel(d);
      drain();

      // random phase one: both sides idle, receiver more often
      write_reg(REG_INV_FOCAL_X, 24'd16777);
      write_reg(REG_INV_FOCAL_Y, 24'd16777);
      write_reg(REG_CENTER_X, 16'd5120);
      write_reg(REG_CENTER_Y, 16'd3840);
      write_reg(REG_MAX_DEPTH, 16'd10000);
      write_reg(REG_DIFF_RATIO, 16'd6554);
      write_reg(REG_NEIGHBOUR_STEP, 7'd2);
      send_idle_pct = 35; recv_idle_pct = 73;
      random_phase(550);
      drain();

      // random phase two: other intrinsics, sender idles more
      write_reg(REG_INV_FOCAL_X, 24'($urandom_range(16777215, 1)));
      write_reg(REG_INV_FOCAL_Y, 24'($urandom_range(200000, 1)));
      write_reg(REG_CENTER_X, 16'($urandom));
      write_reg(REG_CENTER_Y, 16'($urandom));
      write_reg(REG_MAX_DEPTH, 16'd60000);
      write_reg(REG_DIFF_RATIO, 16'd20000);
      write_reg(REG_NEIGHBOUR_STEP, 7'($urandom_range(64, 1)));
      send_idle_pct = 73; recv_idle_pct = 35;
      random_phase(550);
      drain();

      // back pressure: result side held off while pixels keep coming
      send_idle_pct = 0; recv_idle_pct = 0;
      fork
         begin
            hold_rsp = 1'b1;
            repeat (150) @(negedge clock);
            hold_rsp = 1'b0;
         end
         random_phase(100);
      join
      drain();

      // phase three: no idling
      write_reg(REG_NEIGHBOUR_STEP, 7'd1);
      write_reg(REG_DIFF_RATIO, 16'd6554);
      random_phase(500);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("depth_pixel_normal_estimate: match");
      end else begin
         $display("depth_pixel_normal_estimate: mismatch");
      end
      $finish;
   end
endmodule
